// ===== sv/vector_norm_l1_l2_linf_defines.svh =====
// assertion macros shared by the vector norm rtl
`ifndef VECTOR_NORM_L1_L2_LINF_DEFINES_SVH
`define VECTOR_NORM_L1_L2_LINF_DEFINES_SVH

`ifndef SYNTHESIS
// plain property checked on every clock outside reset
`define VN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vnorm assertion failed");
// implication checked on every clock outside reset
`define VN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vnorm assertion failed");
`else
`define VN_ASSERT(lbl, prop)
`define VN_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ===== sv/vnorm_pkg.sv =====
package vnorm_pkg;

  localparam int ElemW       = 24;
  localparam int MagW        = 24;
  localparam int SqProdW     = 2 * MagW;
  localparam int NormW       = 34;
  localparam int SqW         = 57;
  localparam int RootW       = (SqW + 1) / 2;
  localparam int RadW        = 2 * RootW;
  localparam int RemW        = RootW + 3;
  localparam int StepW       = $clog2(RootW);
  localparam int ModeW       = 2;
  localparam int MaxElements = 1024;
  localparam int QueueDepth  = 4;

  localparam logic [ModeW-1:0] ModeL1   = 2'd0;
  localparam logic [ModeW-1:0] ModeL2   = 2'd1;
  localparam logic [ModeW-1:0] ModeLinf = 2'd2;

  typedef enum logic {
    BK_IDLE,
    BK_ROOT
  } back_state_e;

  // one finished vector, handed from the front to the back
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [NormW-1:0] direct;
    logic [SqW-1:0]   sq_sum;
    logic             ovf;
  } vec_rec_t;

endpackage

// ===== sv/vnorm_in_if.sv =====
interface vnorm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [vnorm_pkg::ElemW-1:0]  element;
  logic                                last;

  modport source (output valid, output element, output last, input ready);
  modport sink (input valid, input element, input last, output ready);
endinterface

// ===== sv/vnorm_out_if.sv =====
interface vnorm_out_if;
  logic                          valid;
  logic                          ready;
  logic [vnorm_pkg::NormW-1:0]   norm_value;
  logic                          saturated;

  modport source (output valid, output norm_value, output saturated, input ready);
  modport sink (input valid, input norm_value, input saturated, output ready);
endinterface

// ===== sv/vnorm_fifo.sv =====
`include "vector_norm_l1_l2_linf_defines.svh"

module vnorm_fifo #(
  parameter int DEPTH = vnorm_pkg::QueueDepth,
  localparam int CntW = $clog2(DEPTH + 1),
  localparam int PtrW = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vnorm_pkg::vec_rec_t wdata_i,
  input  logic                pop_i,
  output vnorm_pkg::vec_rec_t rdata_o,
  output logic                empty_o,
  output logic [CntW-1:0]     count_o
);

  vnorm_pkg::vec_rec_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  `VN_ASSERT_IMPL(a_push_has_room, push_i, count_q != CntW'(DEPTH))
  `VN_ASSERT_IMPL(a_pop_has_data, pop_i, count_q != '0)

endmodule

// ===== sv/vnorm_front.sv =====
`include "vector_norm_l1_l2_linf_defines.svh"

module vnorm_front #(
  parameter int MAX_ELEMENTS = vnorm_pkg::MaxElements,
  parameter int QUEUE_DEPTH  = vnorm_pkg::QueueDepth,
  localparam int QCntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [vnorm_pkg::ModeW-1:0]         norm_mode_i,
  input  logic                                in_valid_i,
  input  logic signed [vnorm_pkg::ElemW-1:0]  element_i,
  input  logic                                last_i,
  output logic                                in_ready_o,
  input  logic [QCntW-1:0]                    q_count_i,
  output logic                                push_o,
  output vnorm_pkg::vec_rec_t                 rec_o
);

  localparam int CntW  = $clog2(MAX_ELEMENTS + 1);
  localparam int PendW = QCntW + 1;
  localparam int MagW  = vnorm_pkg::MagW;
  localparam int NormW = vnorm_pkg::NormW;
  localparam int SqW   = vnorm_pkg::SqW;

  logic                         accept;
  logic [PendW-1:0]             pending;
  logic [vnorm_pkg::ElemW-1:0]  neg;
  logic [MagW-1:0]              mag_in;

  // stage 1: magnitude, stage 2: square
  logic                          v1_q, v2_q;
  logic                          last1_q, last2_q;
  logic [MagW-1:0]               mag1_q, mag2_q;
  logic [vnorm_pkg::SqProdW-1:0] sq2_q;

  // vector accumulators
  logic [NormW-1:0] msum_q, msum_new;
  logic [SqW-1:0]   ssum_q, ssum_new;
  logic [MagW-1:0]  big_q, big_new;
  logic [CntW-1:0]  cnt_q, cnt_new;
  logic             ovf_q, ovf_new;
  logic             full;
  logic [NormW:0]   msum_ext;
  logic [SqW:0]     ssum_ext;
  logic [NormW-1:0] direct;

  // every item in flight may end a vector, so each needs a queue slot
  assign pending    = PendW'(q_count_i) + PendW'(v1_q) + PendW'(v2_q);
  assign in_ready_o = (pending < PendW'(QUEUE_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  assign neg    = ~$unsigned(element_i) + vnorm_pkg::ElemW'(1);
  assign mag_in = element_i[vnorm_pkg::ElemW-1] ? MagW'(neg) : MagW'($unsigned(element_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag1_q  <= mag_in;
    last1_q <= last_i;
    mag2_q  <= mag1_q;
    last2_q <= last1_q;
    sq2_q   <= mag1_q * mag1_q;
  end

  always_comb begin
    full     = !(cnt_q < CntW'(MAX_ELEMENTS));
    msum_ext = {1'b0, msum_q} + (NormW + 1)'(mag2_q);
    ssum_ext = {1'b0, ssum_q} + (SqW + 1)'(sq2_q);
    if (full) begin
      msum_new = msum_q;
      ssum_new = ssum_q;
      big_new  = big_q;
      cnt_new  = cnt_q;
      ovf_new  = 1'b1;
    end else begin
      msum_new = msum_ext[NormW] ? '1 : msum_ext[NormW-1:0];
      ssum_new = ssum_ext[SqW] ? '1 : ssum_ext[SqW-1:0];
      big_new  = (mag2_q > big_q) ? mag2_q : big_q;
      cnt_new  = cnt_q + CntW'(1);
      ovf_new  = ovf_q | msum_ext[NormW] | ssum_ext[SqW];
    end
  end

  always_comb begin
    case (norm_mode_i)
      vnorm_pkg::ModeL1:   direct = msum_new;
      vnorm_pkg::ModeLinf: direct = NormW'(big_new);
      default:             direct = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msum_q <= '0;
      ssum_q <= '0;
      big_q  <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (v2_q) begin
      if (last2_q) begin
        msum_q <= '0;
        ssum_q <= '0;
        big_q  <= '0;
        cnt_q  <= '0;
        ovf_q  <= 1'b0;
      end else begin
        msum_q <= msum_new;
        ssum_q <= ssum_new;
        big_q  <= big_new;
        cnt_q  <= cnt_new;
        ovf_q  <= ovf_new;
      end
    end
  end

  assign push_o        = v2_q && last2_q;
  assign rec_o.mode    = norm_mode_i;
  assign rec_o.direct  = direct;
  assign rec_o.sq_sum  = ssum_new;
  assign rec_o.ovf     = ovf_new;

  `VN_ASSERT(a_count_bound, cnt_q <= CntW'(MAX_ELEMENTS))

endmodule

// ===== sv/vnorm_back.sv =====
`include "vector_norm_l1_l2_linf_defines.svh"

module vnorm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  vnorm_pkg::vec_rec_t          rec_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  output logic [vnorm_pkg::NormW-1:0]  norm_value_o,
  output logic                         saturated_o,
  input  logic                         out_ready_i
);

  localparam int RootW = vnorm_pkg::RootW;
  localparam int RadW  = vnorm_pkg::RadW;
  localparam int RemW  = vnorm_pkg::RemW;
  localparam int StepW = vnorm_pkg::StepW;
  localparam int NormW = vnorm_pkg::NormW;

  vnorm_pkg::back_state_e state_q, state_d;

  logic [StepW-1:0] step_q;
  logic [RadW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q, rem_sh, trial, rem_nx;
  logic [RootW-1:0] root_q, root_nx;
  logic             ovf_q;
  logic             ge;

  logic             out_valid_q, out_valid_d;
  logic [NormW-1:0] out_value_q;
  logic             out_sat_q;

  logic is_l2;
  logic load_direct;
  logic load_root;
  logic root_done;

  assign is_l2 = (rec_i.mode == vnorm_pkg::ModeL2);

  // one root bit per cycle, two radicand bits shifted in
  always_comb begin
    rem_sh  = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
    trial   = RemW'({root_q, 2'b01});
    ge      = (rem_sh >= trial);
    rem_nx  = ge ? rem_sh - trial : rem_sh;
    root_nx = {root_q[RootW-2:0], ge};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vnorm_pkg::BK_IDLE: begin
        if (pop_o && is_l2) begin
          state_d = vnorm_pkg::BK_ROOT;
        end
      end
      vnorm_pkg::BK_ROOT: begin
        if (step_q == '0) begin
          state_d = vnorm_pkg::BK_IDLE;
        end
      end
      default: state_d = vnorm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    load_direct = 1'b0;
    load_root   = 1'b0;
    root_done   = 1'b0;
    unique case (state_q)
      vnorm_pkg::BK_IDLE: begin
        pop_o       = !q_empty_i && (!out_valid_q || out_ready_i);
        load_direct = pop_o && !is_l2;
        load_root   = pop_o && is_l2;
      end
      vnorm_pkg::BK_ROOT: begin
        root_done = (step_q == '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_direct || root_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vnorm_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_root) begin
      rad_q  <= RadW'(rec_i.sq_sum);
      rem_q  <= '0;
      root_q <= '0;
      step_q <= StepW'(RootW - 1);
      ovf_q  <= rec_i.ovf;
    end else if (state_q == vnorm_pkg::BK_ROOT) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= rem_nx;
      root_q <= root_nx;
      step_q <= step_q - StepW'(1);
    end
    if (load_direct) begin
      out_value_q <= rec_i.direct;
      out_sat_q   <= rec_i.ovf;
    end else if (root_done) begin
      out_value_q <= NormW'(root_nx);
      out_sat_q   <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign norm_value_o = out_value_q;
  assign saturated_o  = out_sat_q;

  `VN_ASSERT_IMPL(a_root_slot_free, state_q == vnorm_pkg::BK_ROOT, !out_valid_q)

endmodule

// ===== sv/vector_norm_l1_l2_linf.sv =====
// streaming vector norm: L1, L2 (floor integer root) or L-infinity
// elem_i carries one signed 24-bit element per transfer, with last on the
// final element of a vector. norm_o carries one result per vector: the norm
// picked by the mode register and a flag that the vector ran past
// MAX_ELEMENTS or an accumulator clamped. cfg_we_i/cfg_wdata_i write the
// 2-bit mode (0 L1, 1 L2, 2 L-inf, 3 gives zero); write it only while idle.
// the front takes one element per cycle while ready is high: magnitude,
// square and accumulate in three stages, then the finished vector enters a
// QUEUE_DEPTH queue. L1 and L-inf results pass the back directly, while for
// L2 the back runs a bit-serial square root and pops no new vector from the
// queue until the root is done.
// a stalled receiver holds the result; the front keeps taking elements until
// the queue plus the items in its pipeline reach QUEUE_DEPTH, then drops ready.
// reset clears the mode to L1 and all vector state; no clearing pass needed.

module vector_norm_l1_l2_linf #(
  parameter int MAX_ELEMENTS = vnorm_pkg::MaxElements,
  parameter int QUEUE_DEPTH  = vnorm_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [vnorm_pkg::ModeW-1:0] cfg_wdata_i,
  vnorm_in_if.sink                    elem_i,
  vnorm_out_if.source                 norm_o
);

  localparam int QCntW = $clog2(QUEUE_DEPTH + 1);

  logic [vnorm_pkg::ModeW-1:0] norm_mode_q;
  logic [QCntW-1:0]            q_count;
  logic                        push;
  logic                        pop;
  logic                        q_empty;
  vnorm_pkg::vec_rec_t         rec_in;
  vnorm_pkg::vec_rec_t         rec_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_mode_q <= vnorm_pkg::ModeL1;
    end else if (cfg_we_i) begin
      norm_mode_q <= cfg_wdata_i;
    end
  end

  vnorm_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .norm_mode_i (norm_mode_q),
    .in_valid_i  (elem_i.valid),
    .element_i   (elem_i.element),
    .last_i      (elem_i.last),
    .in_ready_o  (elem_i.ready),
    .q_count_i   (q_count),
    .push_o      (push),
    .rec_o       (rec_in)
  );

  vnorm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (rec_in),
    .pop_i   (pop),
    .rdata_o (rec_out),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  vnorm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .rec_i        (rec_out),
    .pop_o        (pop),
    .out_valid_o  (norm_o.valid),
    .norm_value_o (norm_o.norm_value),
    .saturated_o  (norm_o.saturated),
    .out_ready_i  (norm_o.ready)
  );

endmodule
